// File: rtl/fet_pkg.sv
// Shared types and constants for the flash erase-once tracker.
// Holds the sequencer control word, status bundle, result kinds and sizing.
// No dependencies.
package fet_pkg;

	// Map sizing: one bit per erase block, stored as rows of 64 bits
	localparam int NumBlocks = 4096;
	localparam int BlkW      = $clog2(NumBlocks);
	localparam int RowBits   = 64;
	localparam int RowSelW   = $clog2(RowBits);
	localparam int NumRows   = NumBlocks / RowBits;
	localparam int RowIdxW   = $clog2(NumRows);
	localparam int MaxSpan   = 63;

	// Field widths
	localparam int AddrW  = 32;
	localparam int LenW   = 25;
	localparam int BsW    = 17;
	localparam int BcW    = 13;
	localparam int DivW   = AddrW + 1;
	localparam int DivCntW = $clog2(DivW + 1);
	localparam int PcW    = 4;

	// Configuration register indexes
	localparam logic [7:0] CfgBlockSize  = 8'd0;
	localparam logic [7:0] CfgBlockCount = 8'd1;

	typedef enum logic [1:0] {
		KIND_ERASE  = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SPAN,
		OP_MEM_RD,
		OP_ROW_LOAD,
		OP_BIT,
		OP_MEM_WR,
		OP_EMIT_WRITE,
		OP_EMIT_REJECT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_LEN_ZERO,
		C_CFG_BAD,
		C_DIV_BUSY,
		C_OUT_RANGE,
		C_ROW_OPEN,
		C_WALK_MORE
	} cond_t;

	typedef struct packed {
		op_t            op;
		cond_t          cond;
		logic [PcW-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic len_zero;
		logic cfg_bad;
		logic div_busy;
		logic out_range;
		logic row_open;
		logic walk_more;
	} stat_t;

endpackage

// File: rtl/fet_seq.sv
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on fet_pkg for the control word and status types.
module fet_seq
	import fet_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	input  logic  hold,
	output op_t   op
);

	// Step numbers of the program
	localparam logic [PcW-1:0] StIdle   = 4'd0;
	localparam logic [PcW-1:0] StZero   = 4'd1;
	localparam logic [PcW-1:0] StCfg    = 4'd2;
	localparam logic [PcW-1:0] StDiv    = 4'd3;
	localparam logic [PcW-1:0] StSpan   = 4'd4;
	localparam logic [PcW-1:0] StRowRd  = 4'd5;
	localparam logic [PcW-1:0] StRowLd  = 4'd6;
	localparam logic [PcW-1:0] StBit    = 4'd7;
	localparam logic [PcW-1:0] StRowWr  = 4'd8;
	localparam logic [PcW-1:0] StWrite  = 4'd9;
	localparam logic [PcW-1:0] StReject = 4'd10;

	logic [PcW-1:0] pc_q;
	ctrl_word_t     cw;
	logic           take;

	// Control store
	function automatic ctrl_word_t rom(input logic [PcW-1:0] pc);
		ctrl_word_t w;
		case (pc)
			StIdle:   w = '{op: OP_ACCEPT,      cond: C_NO_INPUT,  target: StIdle};
			StZero:   w = '{op: OP_NONE,        cond: C_LEN_ZERO,  target: StWrite};
			StCfg:    w = '{op: OP_DIV_INIT,    cond: C_CFG_BAD,   target: StReject};
			StDiv:    w = '{op: OP_DIV_STEP,    cond: C_DIV_BUSY,  target: StDiv};
			StSpan:   w = '{op: OP_SPAN,        cond: C_OUT_RANGE, target: StReject};
			StRowRd:  w = '{op: OP_MEM_RD,      cond: C_NEVER,     target: StIdle};
			StRowLd:  w = '{op: OP_ROW_LOAD,    cond: C_NEVER,     target: StIdle};
			StBit:    w = '{op: OP_BIT,         cond: C_ROW_OPEN,  target: StBit};
			StRowWr:  w = '{op: OP_MEM_WR,      cond: C_WALK_MORE, target: StRowRd};
			StWrite:  w = '{op: OP_EMIT_WRITE,  cond: C_ALWAYS,    target: StIdle};
			StReject: w = '{op: OP_EMIT_REJECT, cond: C_ALWAYS,    target: StIdle};
			default:  w = '{op: OP_NONE,        cond: C_ALWAYS,    target: StIdle};
		endcase
		return w;
	endfunction

	assign cw = rom(pc_q);
	assign op = cw.op;

	// Select the jump condition
	always_comb begin
		case (cw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_INPUT:  take = !stat.in_valid;
			C_LEN_ZERO:  take = stat.len_zero;
			C_CFG_BAD:   take = stat.cfg_bad;
			C_DIV_BUSY:  take = stat.div_busy;
			C_OUT_RANGE: take = stat.out_range;
			C_ROW_OPEN:  take = stat.row_open;
			C_WALK_MORE: take = stat.walk_more;
			default:     take = 1'b1;
		endcase
	end

	// Advance the step counter unless the output stage stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= StIdle;
		end else if (!hold) begin
			pc_q <= take ? cw.target : pc_q + 1'b1;
		end
	end

endmodule

// File: rtl/fet_div.sv
// Two-lane restoring divider, one quotient bit per lane per cycle.
// Gives the first and last block of a span. Depends on fet_pkg for widths.
module fet_div
	import fet_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            init,
	input  logic            step,
	input  logic [DivW-1:0] dvd_a,
	input  logic [DivW-1:0] dvd_b,
	input  logic [BsW-1:0]  dvsr,
	output logic [DivW-1:0] q_a,
	output logic [DivW-1:0] q_b,
	output logic            busy
);

	logic [DivW-1:0]    qa_q, qb_q;
	logic [BsW-1:0]     ra_q, rb_q;
	logic [DivCntW-1:0] cnt_q;
	logic [BsW:0]       sa, sb, da, db;
	logic               ga, gb;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		sa = {ra_q, qa_q[DivW-1]};
		sb = {rb_q, qb_q[DivW-1]};
		ga = sa >= {1'b0, dvsr};
		gb = sb >= {1'b0, dvsr};
		da = ga ? sa - {1'b0, dvsr} : sa;
		db = gb ? sb - {1'b0, dvsr} : sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= DivCntW'(DivW);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Quotient bits enter at the bottom as dividend bits leave at the top
	always_ff @(posedge clk) begin
		if (init) begin
			qa_q <= dvd_a;
			qb_q <= dvd_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (step) begin
			qa_q <= {qa_q[DivW-2:0], ga};
			qb_q <= {qb_q[DivW-2:0], gb};
			ra_q <= da[BsW-1:0];
			rb_q <= db[BsW-1:0];
		end
	end

	assign q_a  = qa_q;
	assign q_b  = qb_q;
	assign busy = cnt_q > DivCntW'(1);

endmodule

// File: rtl/fet_map.sv
// Erased-block map: rows of 64 bits in a memory with one read and one write port and registered read.
// A row-valid flag per row stands in for clearing at reset. Depends on fet_pkg.
module fet_map
	import fet_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [RowIdxW-1:0] rd_row,
	input  logic               wr_en,
	input  logic [RowIdxW-1:0] wr_row,
	input  logic [RowBits-1:0] wr_data,
	output logic [RowBits-1:0] rd_data
);

	logic [RowBits-1:0] mem [NumRows];
	logic [NumRows-1:0] valid_q;
	logic [RowBits-1:0] rd_data_q;
	logic               rd_hit_q;

	// Mark rows written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_row] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
			rd_hit_q  <= valid_q[rd_row];
		end
	end

	// A row never written reads as all clear
	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

// File: rtl/flash_erase_once_tracker_top.sv
// Flash erase-once tracker, top level: ports, config registers and the datapath.
// Instantiates fet_seq, fet_div and fet_map; depends on fet_pkg.
//
// Takes one write request at a time and turns it into erase commands for every block of
// the span not yet erased since reset, in ascending order, then one write command flagged
// last; an out-of-device or too-long span gives one reject beat instead. A zero-length
// request goes straight to the write command and a bad configuration to a reject; any
// other request runs the two-lane divider (first and last block), then reads, walks and
// writes back each map row touched (one or two); emitting steps stall on the output.
// The map needs no clearing pass after reset.
module flash_erase_once_tracker_top
	import fet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // start_address[31:0], length[56:32], zero pad
	// Command stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // target_address[31:0], byte_count[56:32], zero pad
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast,
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	logic [BsW-1:0]     bs_q;
	logic [BcW-1:0]     bc_q, eff_count;
	logic [AddrW-1:0]   addr_q, acc_q;
	logic [LenW-1:0]    len_q;
	logic [DivW-1:0]    end_addr, q_first, q_last;
	logic [BlkW-1:0]    b_q, last_blk;
	logic [RowBits-1:0] row_q, rd_row_data;
	logic [RowIdxW-1:0] row_idx_q;
	logic [BlkW+BsW-1:0] prod;
	logic               done_q, div_busy, bit_set, emit_req, hold, fire;
	op_t                op;
	stat_t              stat;

	logic               out_valid_q, out_last_q;
	kind_t              out_kind_q;
	logic [AddrW-1:0]   out_addr_q;
	logic [LenW-1:0]    out_cnt_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BsW'(512);
			bc_q <= BcW'(NumBlocks);
		end else if (cfg_valid) begin
			if (cfg_index == CfgBlockSize) begin
				bs_q <= cfg_data;
			end else if (cfg_index == CfgBlockCount) begin
				bc_q <= cfg_data[BcW-1:0];
			end
		end
	end

	assign eff_count = (bc_q > BcW'(NumBlocks)) ? BcW'(NumBlocks) : bc_q;

	// Sequencer and status
	assign end_addr = {1'b0, addr_q} + DivW'(len_q) - DivW'(1);
	assign last_blk = q_last[BlkW-1:0];
	assign bit_set  = row_q[b_q[RowSelW-1:0]];

	always_comb begin
		stat.in_valid  = s_tvalid;
		stat.len_zero  = len_q == '0;
		stat.cfg_bad   = (bs_q == '0) || (bc_q == '0);
		stat.div_busy  = div_busy;
		stat.out_range = (q_last >= DivW'(eff_count)) ||
		                 ((q_last - q_first) >= DivW'(MaxSpan));
		stat.row_open  = !((b_q == last_blk) || (&b_q[RowSelW-1:0]));
		stat.walk_more = !done_q;
	end

	fet_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.hold   (hold),
		.op     (op)
	);

	fet_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (op == OP_DIV_INIT),
		.step   (op == OP_DIV_STEP),
		.dvd_a  ({1'b0, addr_q}),
		.dvd_b  (end_addr),
		.dvsr   (bs_q),
		.q_a    (q_first),
		.q_b    (q_last),
		.busy   (div_busy)
	);

	fet_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (op == OP_MEM_RD),
		.rd_row  (b_q[BlkW-1:RowSelW]),
		.wr_en   (op == OP_MEM_WR),
		.wr_row  (row_idx_q),
		.wr_data (row_q),
		.rd_data (rd_row_data)
	);

	// Stall a step that emits while the output register is still full
	assign emit_req = (op == OP_EMIT_WRITE) || (op == OP_EMIT_REJECT) ||
	                  ((op == OP_BIT) && !bit_set);
	assign hold     = emit_req && out_valid_q && !m_tready;
	assign fire     = !hold;
	assign s_tready = op == OP_ACCEPT;

	assign prod = q_first[BlkW-1:0] * bs_q;

	// Request capture and block walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (fire && op == OP_SPAN) begin
			done_q <= 1'b0;
		end else if (fire && op == OP_BIT) begin
			done_q <= b_q == last_blk;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_ACCEPT && s_tvalid) begin
			addr_q <= s_tdata[AddrW-1:0];
			len_q  <= s_tdata[AddrW+LenW-1:AddrW];
		end
		if (fire) begin
			case (op)
				OP_SPAN: begin
					b_q   <= q_first[BlkW-1:0];
					acc_q <= AddrW'(prod);
				end
				OP_MEM_RD: begin
					row_idx_q <= b_q[BlkW-1:RowSelW];
				end
				OP_ROW_LOAD: begin
					row_q <= rd_row_data;
				end
				OP_BIT: begin
					row_q[b_q[RowSelW-1:0]] <= 1'b1;
					b_q   <= b_q + 1'b1;
					acc_q <= acc_q + AddrW'(bs_q);
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: load a beat when a step emits, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_req && fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && fire) begin
			case (op)
				OP_EMIT_WRITE: begin
					out_kind_q <= KIND_WRITE;
					out_addr_q <= addr_q;
					out_cnt_q  <= len_q;
					out_last_q <= 1'b1;
				end
				OP_EMIT_REJECT: begin
					out_kind_q <= KIND_REJECT;
					out_addr_q <= addr_q;
					out_cnt_q  <= '0;
					out_last_q <= 1'b1;
				end
				default: begin
					out_kind_q <= KIND_ERASE;
					out_addr_q <= acc_q;
					out_cnt_q  <= '0;
					out_last_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_addr_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// No new request is taken right after one is accepted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while the previous one is in work");

	// Only erase beats go out without last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != KIND_ERASE)))
		else $error("last flag does not match result kind");

	// An erase is only issued for a block inside the device
	a_erase_in_device: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op == OP_BIT && !bit_set) |-> ({1'b0, b_q} < eff_count))
		else $error("erase issued beyond the block count");
`endif

endmodule
